// ===== sv/lcrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcrs_pkg
// shared widths, constants and gold sequence lfsr helpers for the crs generator
// ----------------------------------------------------------------------------
package lcrs_pkg;

	localparam int LFSR_W         = 31;
	localparam int GOLD_NC        = 1600;
	localparam int NC_STEPS       = GOLD_NC - LFSR_W;
	localparam int CRS_LENGTH_DEF = 220;

	localparam int SLOT_W    = 5;
	localparam int SYMBOL_W  = 3;
	localparam int CELL_ID_W = 9;
	localparam int VALUE_W   = 16;
	localparam int INDEX_W   = 8;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 40;

	localparam logic signed [VALUE_W-1:0] QPSK_AMP = 16'sd23170;

	typedef logic [LFSR_W-1:0] lfsr_t;

	// one accepted item after seeding
	typedef struct packed {
		logic  restart;
		lfsr_t seed;
	} item_t;

	function automatic logic x1_fb(input lfsr_t v);
		return v[0] ^ v[3];
	endfunction

	function automatic logic x2_fb(input lfsr_t v);
		return v[0] ^ v[1] ^ v[2] ^ v[3];
	endfunction

	function automatic lfsr_t x1_next(input lfsr_t v);
		return {x1_fb(v), v[LFSR_W-1:1]};
	endfunction

	function automatic lfsr_t x2_next(input lfsr_t v);
		return {x2_fb(v), v[LFSR_W-1:1]};
	endfunction

	// x1 state after the nc offset, starting from x1 = 1
	function automatic lfsr_t x1_jump();
		lfsr_t v;
		v = lfsr_t'(1);
		for (int i = 0; i < NC_STEPS; i++) begin
			v = x1_next(v);
		end
		return v;
	endfunction

	// columns of the x2 transition matrix raised to the nc offset
	function automatic logic [LFSR_W-1:0][LFSR_W-1:0] x2_jump_cols();
		logic [LFSR_W-1:0][LFSR_W-1:0] cols;
		lfsr_t v;
		for (int j = 0; j < LFSR_W; j++) begin
			v = lfsr_t'(1) << j;
			for (int i = 0; i < NC_STEPS; i++) begin
				v = x2_next(v);
			end
			cols[j] = v;
		end
		return cols;
	endfunction

	localparam lfsr_t X1_NC = x1_jump();
	localparam logic [LFSR_W-1:0][LFSR_W-1:0] X2_NC_COLS = x2_jump_cols();

	function automatic logic signed [VALUE_W-1:0] qpsk_level(input logic b);
		return b ? -QPSK_AMP : QPSK_AMP;
	endfunction

endpackage

// ===== sv/lcrs_seed.sv =====
// ----------------------------------------------------------------------------
// lcrs_seed
// forms c_init from slot, symbol and cell id and jumps x2 over the nc offset
// ----------------------------------------------------------------------------
module lcrs_seed (
	input  logic [lcrs_pkg::SLOT_W-1:0]    slot,
	input  logic [lcrs_pkg::SYMBOL_W-1:0]  symbol,
	input  logic [lcrs_pkg::CELL_ID_W-1:0] cell_id,
	input  logic                           cp_normal,
	output lcrs_pkg::lfsr_t                seed
);

	logic [7:0]            term_a;
	logic [9:0]            term_b;
	logic [17:0]           prod;
	lcrs_pkg::lfsr_t       c_init;
	lcrs_pkg::lfsr_t       acc;

	// 7*(slot+1)+symbol+1, at most 232
	assign term_a = 8'(slot) * 8'd7 + 8'(symbol) + 8'd8;
	assign term_b = {cell_id, 1'b1};
	assign prod   = 18'(term_a) * 18'(term_b);

	// low term 2*cell_id+cp stays below 1024, so it simply fills the low bits
	assign c_init = {3'b000, prod, cell_id, cp_normal};

	// x2 after the offset is linear in c_init
	always_comb begin
		acc = '0;
		for (int j = 0; j < lcrs_pkg::LFSR_W; j++) begin
			if (c_init[j]) begin
				acc = acc ^ lcrs_pkg::X2_NC_COLS[j];
			end
		end
	end

	assign seed = acc;

endmodule

// ===== sv/lcrs_core.sv =====
// ----------------------------------------------------------------------------
// lcrs_core
// gold lfsr state, two steps per symbol, qpsk mapping and output register
// ----------------------------------------------------------------------------
module lcrs_core #(
	parameter int CRS_LENGTH = lcrs_pkg::CRS_LENGTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  lcrs_pkg::item_t                     in_item,
	output logic                                in_take,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [lcrs_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                                m_tlast
);

	localparam int CNT_W = $clog2(CRS_LENGTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CRS_LENGTH - 1);

	lcrs_pkg::lfsr_t   lfsr1_q;
	lcrs_pkg::lfsr_t   lfsr2_q;
	logic [CNT_W-1:0]  cnt_q;

	lcrs_pkg::lfsr_t   base1;
	lcrs_pkg::lfsr_t   base2;
	lcrs_pkg::lfsr_t   mid1;
	lcrs_pkg::lfsr_t   mid2;
	logic              bit0;
	logic              bit1;
	logic [CNT_W-1:0]  idx;
	logic              is_last;
	logic              advance;

	logic signed [lcrs_pkg::VALUE_W-1:0] re_q;
	logic signed [lcrs_pkg::VALUE_W-1:0] im_q;
	logic [lcrs_pkg::INDEX_W-1:0]        index_q;
	logic                                last_q;
	logic                                out_valid_q;

	assign in_take = !out_valid_q || m_tready;
	assign advance = in_valid && in_take;

	always_comb begin
		base1   = in_item.restart ? lcrs_pkg::X1_NC : lfsr1_q;
		base2   = in_item.restart ? in_item.seed : lfsr2_q;
		bit0    = lcrs_pkg::x1_fb(base1) ^ lcrs_pkg::x2_fb(base2);
		mid1    = lcrs_pkg::x1_next(base1);
		mid2    = lcrs_pkg::x2_next(base2);
		bit1    = lcrs_pkg::x1_fb(mid1) ^ lcrs_pkg::x2_fb(mid2);
		idx     = in_item.restart ? '0 : cnt_q;
		is_last = (idx == CNT_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr1_q     <= lcrs_pkg::lfsr_t'(1);
			lfsr2_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				lfsr1_q <= lcrs_pkg::x1_next(mid1);
				lfsr2_q <= lcrs_pkg::x2_next(mid2);
				cnt_q   <= is_last ? '0 : idx + 1'b1;
			end
			if (in_take) begin
				out_valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			re_q    <= lcrs_pkg::qpsk_level(bit0);
			im_q    <= lcrs_pkg::qpsk_level(bit1);
			index_q <= lcrs_pkg::INDEX_W'(idx);
			last_q  <= is_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {index_q, im_q, re_q};
	assign m_tlast  = last_q;

`ifndef SYNTH
	a_x1_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr1_q != '0)
		else $error("x1 lfsr reached the all-zero state");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cnt_q} < (CNT_W + 1)'(CRS_LENGTH))
		else $error("symbol counter out of range");

	a_restart_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && in_item.restart) |=> (cnt_q == CNT_W'(1)))
		else $error("counter not restarted by restart item");

	a_amp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((re_q == lcrs_pkg::QPSK_AMP || re_q == -lcrs_pkg::QPSK_AMP)
			&& (im_q == lcrs_pkg::QPSK_AMP || im_q == -lcrs_pkg::QPSK_AMP)))
		else $error("qpsk level not plus or minus amplitude");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (index_q == lcrs_pkg::INDEX_W'(CRS_LENGTH - 1)))
		else $error("last flag on wrong index");
`endif

endmodule

// ===== sv/lte_crs_gold_sequence_qpsk.sv =====
// ----------------------------------------------------------------------------
// lte_crs_gold_sequence_qpsk
// cell reference signal generator: gold sequence mapped to qpsk symbols
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one request per symbol; s_tuser[0] set reseeds from slot,
//   symbol and cell id (c_init, x1 = 1, x2 = c_init, nc offset) before output.
//   m_* returns one qpsk symbol per request, with its index and tlast on the
//   last symbol of a CRS_LENGTH run; the index wraps, the sequence runs on.
//   cfg_* writes cp_normal (reset 1); write it only while the block is idle.
// timing:
//   the nc offset is a constant xor network, so a reseed never stalls requests.
//   a request passes the input register, then the result register, before
//   m_tvalid; one request is taken every cycle while the output does not stall.
// reset and stall:
//   arst_n clears both pipeline stages and loads x1 = 1, x2 = 0, index 0;
//   requests before the first reseed run on from that state.
//   when m_tready is low the result register holds and one more request
//   sits in the input register, then s_tready drops.
// ----------------------------------------------------------------------------
module lte_crs_gold_sequence_qpsk #(
	parameter int CRS_LENGTH = lcrs_pkg::CRS_LENGTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [0:0]                        cfg_data,   // cp_normal
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// slot[4:0], symbol[7:5], cell_id[16:8], zero pad
	input  logic [lcrs_pkg::S_TDATA_W-1:0]    s_tdata,
	input  logic [0:0]                        s_tuser,    // restart
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// re_value[15:0], im_value[31:16], index[39:32]
	output logic [lcrs_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                              m_tlast
);

	logic             cp_normal_q;
	lcrs_pkg::lfsr_t  seed;
	lcrs_pkg::item_t  item_s1;
	logic             valid_s1;
	logic             take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_normal_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			cp_normal_q <= cfg_data[0];
		end
	end

	lcrs_seed u_seed (
		.slot      (s_tdata[4:0]),
		.symbol    (s_tdata[7:5]),
		.cell_id   (s_tdata[16:8]),
		.cp_normal (cp_normal_q),
		.seed      (seed)
	);

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.restart <= s_tuser[0];
			item_s1.seed    <= seed;
		end
	end

	lcrs_core #(
		.CRS_LENGTH (CRS_LENGTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_item  (item_s1),
		.in_take  (take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
